### design/cluster_height_validator_defines.svh
// ----------------------------------------------------------------------------
// Cluster height validator assertion macros
// Shared property forms for the checkers of the cluster height validator.
// ----------------------------------------------------------------------------
`ifndef CLUSTER_HEIGHT_VALIDATOR_DEFINES_SVH
`define CLUSTER_HEIGHT_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define CHV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cluster_height_validator check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define CHV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cluster_height_validator check failed");

`endif

### design/chv_pkg.sv
// ----------------------------------------------------------------------------
// Cluster height validator package
// Word types, register indexes, sequencer states and default constants.
// ----------------------------------------------------------------------------
package chv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int COORD_W       = 32;
  localparam int COEF_W        = 18;
  localparam int HEIGHT_W      = 32;
  localparam int RATIO_W       = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_HEIGHT       = 3'd0,
    CFG_LARGE_MAX_HEIGHT = 3'd1,
    CFG_SMALL_MAX_HEIGHT = 3'd2,
    CFG_HEIGHT_CAP       = 3'd3,
    CFG_PLANE_A          = 3'd4,
    CFG_PLANE_B          = 3'd5,
    CFG_PLANE_C          = 3'd6,
    CFG_PLANE_OFFSET     = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIST,
    ST_UPD,
    ST_FIT,
    ST_MIN,
    ST_TOP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      last_point;
  } in_word_t;

  typedef struct packed {
    logic               is_large;
    logic [RATIO_W-1:0] fit_ratio;
    logic [RATIO_W-1:0] top_ratio;
  } out_word_t;

endpackage

### design/chv_div.sv
// ----------------------------------------------------------------------------
// Cluster height validator ratio divider
// Radix-2 restoring divider giving min((num << FRAC_BITS) / den, 1.0).
// ----------------------------------------------------------------------------
module chv_div
  import chv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [HEIGHT_W-1:0]   num,
  input  logic [HEIGHT_W-1:0]   den,
  output logic                  done,
  output logic [FRAC_BITS:0]    quot
);

  localparam int CNT_W = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [HEIGHT_W-1:0]   rem_r;
  logic [HEIGHT_W-1:0]   den_r;
  logic [FRAC_BITS-1:0]  q_r;
  logic                  done_r;
  logic [FRAC_BITS:0]    quot_r;

  logic [HEIGHT_W:0]     rem_sh;
  logic                  fits;
  logic [HEIGHT_W:0]     rem_sub;
  logic [FRAC_BITS-1:0]  q_nxt;

  always_comb begin
    rem_sh  = {rem_r, 1'b0};
    fits    = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};
    q_nxt   = {q_r[FRAC_BITS-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (num >= den) begin
          done_r <= 1'b1;
          quot_r <= ONE;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= num;
          den_r  <= den;
          q_r    <= '0;
        end
      end else if (busy_r) begin
        rem_r <= fits ? rem_sub[HEIGHT_W-1:0] : rem_sh[HEIGHT_W-1:0];
        q_r   <= q_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= {1'b0, q_nxt};
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### design/cluster_height_validator.sv
// ----------------------------------------------------------------------------
// Cluster height validator
// Tracks the largest point-to-plane distance of a cluster and rates its height.
// ----------------------------------------------------------------------------
// For each point word, one shared 18x32 multiplier forms a*x, b*y
// and c*z in turn and an accumulator adds them to the offset term, after which
// the distance is taken and the running maximum updated. A word with
// last_point set also runs up to three quotients through one shared
// bit-serial divider, where a quotient that saturates to 1.0 skips the bit
// steps, then hands the result word to an output register.
// The top quotient is only divided out when the fit quotient and, if it is
// run, the min quotient both saturate to 1.0.
// The next point word is taken while a result word still waits on out_stall.
// Configuration registers may be written whenever in_stall is low.
module cluster_height_validator
  import chv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int Q_W    = FRAC_BITS + 1;
  localparam int ACC_W  = (FRAC_BITS + 34 > 53) ? FRAC_BITS + 34 : 53;
  localparam int PROD_W = COEF_W + COORD_W;
  localparam int CMP_W  = (Q_W > RATIO_W) ? Q_W : RATIO_W;
  localparam logic [Q_W-1:0] ONE = Q_W'(1) << FRAC_BITS;

  logic [HEIGHT_W-1:0]       min_height_r;
  logic [HEIGHT_W-1:0]       large_max_r;
  logic [HEIGHT_W-1:0]       small_max_r;
  logic [RATIO_W-1:0]        height_cap_r;
  logic signed [COEF_W-1:0]  plane_a_r;
  logic signed [COEF_W-1:0]  plane_b_r;
  logic signed [COEF_W-1:0]  plane_c_r;
  logic signed [COORD_W-1:0] plane_offset_r;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [1:0]                step_r;
  in_word_t                  pt_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [HEIGHT_W-1:0]       dist_r;
  logic [HEIGHT_W-1:0]       max_r;
  logic [HEIGHT_W-1:0]       mx_r;
  logic                      large_r;
  logic [HEIGHT_W-1:0]       limit_r;
  logic [Q_W-1:0]            r1_r;
  logic [Q_W-1:0]            r2_r;
  logic                      div_run_r;
  logic                      out_valid_r;
  out_word_t                 out_data_r;

  logic                      accept;
  logic                      out_free;
  logic signed [COEF_W-1:0]  coef_c;
  logic signed [COORD_W-1:0] coord_c;
  logic [ACC_W-1:0]          mag_c;
  logic [ACC_W-1:0]          mag_sh_c;
  logic [HEIGHT_W-1:0]       dist_c;
  logic [HEIGHT_W-1:0]       newmax_c;
  logic                      large_c;
  logic [HEIGHT_W-1:0]       limit_c;
  logic [Q_W-1:0]            fit_c;
  logic                      div_start;
  logic [HEIGHT_W-1:0]       div_num;
  logic [HEIGHT_W-1:0]       div_den;
  logic                      div_done;
  logic [Q_W-1:0]            div_quot;

  chv_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (step_r == 2'd3) begin
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = pt_r.last_point ? ST_FIT : ST_IDLE;
      end
      ST_FIT: begin
        if (div_done) begin
          state_nxt = (min_height_r != '0) ? ST_MIN : ST_TOP;
        end
      end
      ST_MIN: begin
        if (div_done) begin
          state_nxt = ST_TOP;
        end
      end
      ST_TOP: begin
        if (r1_r != ONE || div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    div_num   = mx_r;
    div_den   = limit_r;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_FIT: begin
        div_start = !div_run_r;
        div_num   = limit_c;
        div_den   = mx_r;
      end
      ST_MIN: begin
        div_start = !div_run_r;
        div_den   = min_height_r;
      end
      ST_TOP: begin
        div_start = !div_run_r && (r1_r == ONE);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    accept   = in_valid && !in_stall;
    out_free = !out_valid_r || !out_stall;
    case (step_r)
      2'd0: begin
        coef_c  = plane_a_r;
        coord_c = pt_r.point_x;
      end
      2'd1: begin
        coef_c  = plane_b_r;
        coord_c = pt_r.point_y;
      end
      default: begin
        coef_c  = plane_c_r;
        coord_c = pt_r.point_z;
      end
    endcase
    mag_c    = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;
    mag_sh_c = mag_c >> FRAC_BITS;
    dist_c   = (|mag_sh_c[ACC_W-1:HEIGHT_W]) ? '1 : mag_sh_c[HEIGHT_W-1:0];
    newmax_c = (dist_r > max_r) ? dist_r : max_r;
    large_c  = mx_r > small_max_r;
    limit_c  = large_c ? large_max_r : small_max_r;
    fit_c    = (CMP_W'(r1_r) < CMP_W'(height_cap_r)) ? '0 : r1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_height_r   <= '0;
      large_max_r    <= HEIGHT_W'(65536);
      small_max_r    <= HEIGHT_W'(32768);
      height_cap_r   <= '0;
      plane_a_r      <= '0;
      plane_b_r      <= '0;
      plane_c_r      <= COEF_W'(65536);
      plane_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN_HEIGHT:       min_height_r   <= cfg_wdata[HEIGHT_W-1:0];
        CFG_LARGE_MAX_HEIGHT: large_max_r    <= cfg_wdata[HEIGHT_W-1:0];
        CFG_SMALL_MAX_HEIGHT: small_max_r    <= cfg_wdata[HEIGHT_W-1:0];
        CFG_HEIGHT_CAP:       height_cap_r   <= cfg_wdata[RATIO_W-1:0];
        CFG_PLANE_A:          plane_a_r      <= cfg_wdata[COEF_W-1:0];
        CFG_PLANE_B:          plane_b_r      <= cfg_wdata[COEF_W-1:0];
        CFG_PLANE_C:          plane_c_r      <= cfg_wdata[COEF_W-1:0];
        CFG_PLANE_OFFSET:     plane_offset_r <= cfg_wdata[COORD_W-1:0];
        default:              plane_offset_r <= plane_offset_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      max_r       <= '0;
      div_run_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (div_start) begin
        div_run_r <= 1'b1;
      end else if (div_done) begin
        div_run_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (accept) begin
            pt_r <= in_data;
          end
        end
        ST_MUL: begin
          step_r <= step_r + 2'd1;
          prod_r <= coef_c * coord_c;
          if (step_r == 2'd0) begin
            acc_r <= ACC_W'(plane_offset_r) <<< FRAC_BITS;
          end else begin
            acc_r <= acc_r + ACC_W'(prod_r);
          end
        end
        ST_DIST: begin
          dist_r <= dist_c;
        end
        ST_UPD: begin
          if (pt_r.last_point) begin
            mx_r  <= newmax_c;
            max_r <= '0;
          end else begin
            max_r <= newmax_c;
          end
        end
        ST_FIT: begin
          if (div_start) begin
            large_r <= large_c;
            limit_r <= limit_c;
          end
          if (div_done) begin
            r1_r <= div_quot;
          end
        end
        ST_MIN: begin
          if (div_done && div_quot < r1_r) begin
            r1_r <= div_quot;
          end
        end
        ST_TOP: begin
          if (r1_r != ONE) begin
            r2_r <= '0;
          end else if (div_done) begin
            r2_r <= div_quot;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_data_r.is_large  <= large_r;
            out_data_r.fit_ratio <= RATIO_W'(fit_c);
            out_data_r.top_ratio <= RATIO_W'(r2_r);
          end
        end
        default: begin
          step_r <= '0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/chv_checker.sv
// ----------------------------------------------------------------------------
// Cluster height validator port checker
// Watches the top-level ports of the validator over time.
// ----------------------------------------------------------------------------
`include "cluster_height_validator_defines.svh"

module chv_checker
  import chv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  localparam logic [RATIO_W-1:0] ONE_OUT = RATIO_W'(64'd1 << FRAC_BITS);

  `CHV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `CHV_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  `CHV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `CHV_ASSERT_NOW(a_top_needs_fit, out_valid && (out_data.top_ratio != '0), (out_data.fit_ratio == ONE_OUT) || (out_data.fit_ratio == '0))

endmodule

bind cluster_height_validator chv_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_chv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
